// ===== rtl/core/lower_triangular_forward_solve_macros.svh =====
// Assertion macros for the forward-substitution solver.
// For the top level's concurrent checks; uses clk_i and rst_ni of the includer.
`ifndef LOWER_TRIANGULAR_FORWARD_SOLVE_MACROS_SVH
`define LOWER_TRIANGULAR_FORWARD_SOLVE_MACROS_SVH

// same-cycle implication
`define LTFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LTFS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ltfs_pkg.sv =====
// Shared constants, status codes and controller/datapath interface types
// for the forward-substitution solver. No dependencies.
package ltfs_pkg;

  localparam int MAX_SIZE    = 64;
  localparam int FRAC_BITS   = 16;
  localparam int ROW_W       = 6;
  localparam int SIZE_W      = 7;
  localparam int DATA_W      = 32;
  localparam int ACC_W       = 2 * DATA_W;
  localparam int ROW_LIMIT   = 1 << ROW_W;
  localparam int STORE_DEPTH = (MAX_SIZE < ROW_LIMIT) ? MAX_SIZE : ROW_LIMIT;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(ACC_W + 1);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
  localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(STORE_DEPTH);

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_DIAG = 2'd1,
    STATUS_SAT       = 2'd2,
    STATUS_ORDER     = 2'd3
  } status_e;

  typedef struct packed {
    logic capture;
    logic rd_issue;
    logic mul;
    logic acc;
    logic num;
    logic div_start;
    logic finish;
    logic res_order;
    logic out_load;
  } ltfs_cmd_t;

  typedef struct packed {
    logic in_order;
    logic is_diag;
    logic coef_zero;
    logic div_busy;
  } ltfs_sts_t;

endpackage

// ===== rtl/core/ltfs_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on ltfs_pkg for widths.
module ltfs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ltfs_pkg::ACC_W-1:0]  num_i,
  input  logic [ltfs_pkg::DATA_W-1:0] den_i,
  output logic                       busy_o,
  output logic [ltfs_pkg::ACC_W-1:0]  quo_o
);
  import ltfs_pkg::*;

  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q;
  logic [ACC_W-1:0]  quo_q;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;

  assign busy_o  = (cnt_q != '0);
  assign quo_o   = quo_q;
  assign shifted = {rem_q, quo_q[ACC_W-1]};
  assign trial   = shifted - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(ACC_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_o) begin
      // remainder stays below den, so the 33-bit trial never loses bits
      if (!trial[DATA_W]) begin
        rem_q <= trial[DATA_W-1:0];
        quo_q <= {quo_q[ACC_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DATA_W-1:0];
        quo_q <= {quo_q[ACC_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/ltfs_dp.sv =====
// Datapath: item capture, order check, solution store, multiply-accumulate,
// numerator, divider and result registers. Depends on ltfs_pkg and ltfs_div.
module ltfs_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ltfs_pkg::SIZE_W-1:0]  cfg_wdata_i,
  input  logic [ltfs_pkg::ROW_W-1:0]   row_i,
  input  logic [ltfs_pkg::ROW_W-1:0]   col_i,
  input  logic signed [ltfs_pkg::DATA_W-1:0] coef_i,
  input  logic signed [ltfs_pkg::DATA_W-1:0] rhs_i,
  input  ltfs_pkg::ltfs_cmd_t          cmd_i,
  output ltfs_pkg::ltfs_sts_t          sts_o,
  output logic [ltfs_pkg::ROW_W-1:0]   index_o,
  output logic signed [ltfs_pkg::DATA_W-1:0] solution_o,
  output logic [1:0]                  status_o,
  output logic                        last_o
);
  import ltfs_pkg::*;

  localparam logic signed [ACC_W-1:0]  MAX64 = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  MIN64 = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] MAX32 = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MIN32 = {1'b1, {(DATA_W-1){1'b0}}};

  // captured beat
  logic [ROW_W-1:0]         row_q, col_q;
  logic signed [DATA_W-1:0] coef_q, rhs_q;

  // sequencing and accumulation state
  logic [ROW_W-1:0]         exp_row_q, exp_col_q;
  logic [SIZE_W-1:0]        size_q;
  logic signed [ACC_W-1:0]  psum_q;
  logic                     sum_ov_q;

  logic [DATA_W-1:0]        store_q [STORE_DEPTH];
  logic signed [DATA_W-1:0] rd_q;
  logic signed [ACC_W-1:0]  prod_q;

  logic [ACC_W-1:0]         num_mag_q;
  logic                     neg_q;
  logic                     ov_q;

  logic [ROW_W-1:0]         res_index_q;
  logic signed [DATA_W-1:0] res_sol_q;
  status_e                  res_status_q;
  logic                     res_last_q;

  logic [ROW_W-1:0]         out_index_q;
  logic signed [DATA_W-1:0] out_sol_q;
  status_e                  out_status_q;
  logic                     out_last_q;

  // derived
  logic [SIZE_W-1:0]        size_eff;
  logic [SIZE_W-1:0]        row_inc;
  logic                     is_last;
  logic signed [ACC_W-1:0]  acc_sum;
  logic                     acc_ovf;
  logic signed [ACC_W-1:0]  rhs_wide;
  logic signed [ACC_W-1:0]  rhs_shift;
  logic signed [ACC_W-1:0]  diff;
  logic                     num_ovf;
  logic signed [ACC_W-1:0]  num_val;
  logic [DATA_W-1:0]        den_mag;
  logic                     div_busy;
  logic [ACC_W-1:0]         quo;
  logic                     q_hi;
  logic                     sat_pos, sat_neg;
  logic signed [DATA_W-1:0] x_d;
  status_e                  x_status;

  always_comb begin
    size_eff = size_q;
    if (size_q == '0) begin
      size_eff = SIZE_W'(1);
    end else if (size_q > SIZE_LIMIT) begin
      size_eff = SIZE_LIMIT;
    end
  end

  assign row_inc = {1'b0, row_q} + SIZE_W'(1);
  assign is_last = (row_inc >= size_eff);

  assign sts_o.in_order  = (row_q == exp_row_q) && (col_q == exp_col_q) &&
                           (int'(row_q) < MAX_SIZE);
  assign sts_o.is_diag   = (col_q == row_q);
  assign sts_o.coef_zero = (coef_q == '0);
  assign sts_o.div_busy  = div_busy;

  // saturating accumulate
  assign acc_sum = psum_q + prod_q;
  assign acc_ovf = (psum_q[ACC_W-1] == prod_q[ACC_W-1]) &&
                   (acc_sum[ACC_W-1] != psum_q[ACC_W-1]);

  // numerator (rhs << FRAC_BITS) - sum, saturated
  assign rhs_wide  = {{(ACC_W-DATA_W){rhs_q[DATA_W-1]}}, rhs_q};
  assign rhs_shift = rhs_wide <<< FRAC_BITS;
  assign diff      = rhs_shift - psum_q;
  assign num_ovf   = (rhs_shift[ACC_W-1] != psum_q[ACC_W-1]) &&
                     (diff[ACC_W-1] != rhs_shift[ACC_W-1]);
  assign num_val   = num_ovf ? (psum_q[ACC_W-1] ? MAX64 : MIN64) : diff;
  assign den_mag   = coef_q[DATA_W-1] ? (-coef_q) : coef_q;

  ltfs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_mag_q),
    .den_i   (den_mag),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // quotient saturation to signed 32 bits
  assign q_hi    = |quo[ACC_W-1:DATA_W];
  assign sat_pos = !neg_q && (q_hi || quo[DATA_W-1]);
  assign sat_neg = neg_q && (q_hi || (quo[DATA_W-1] && (|quo[DATA_W-2:0])));

  always_comb begin
    if (sts_o.coef_zero) begin
      x_d      = '0;
      x_status = STATUS_ZERO_DIAG;
    end else begin
      if (sat_pos) begin
        x_d = MAX32;
      end else if (sat_neg) begin
        x_d = MIN32;
      end else if (neg_q) begin
        x_d = -$signed(quo[DATA_W-1:0]);
      end else begin
        x_d = $signed(quo[DATA_W-1:0]);
      end
      x_status = (ov_q || sat_pos || sat_neg) ? STATUS_SAT : STATUS_OK;
    end
  end

  // control-relevant state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= SIZE_RESET;
      exp_row_q <= '0;
      exp_col_q <= '0;
      psum_q    <= '0;
      sum_ov_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (cmd_i.acc) begin
        psum_q    <= acc_ovf ? (prod_q[ACC_W-1] ? MIN64 : MAX64) : acc_sum;
        sum_ov_q  <= sum_ov_q | acc_ovf;
        exp_col_q <= col_q + ROW_W'(1);
      end
      if (cmd_i.finish) begin
        psum_q    <= '0;
        sum_ov_q  <= 1'b0;
        exp_col_q <= '0;
        exp_row_q <= is_last ? '0 : row_inc[ROW_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_q  <= row_i;
      col_q  <= col_i;
      coef_q <= coef_i;
      rhs_q  <= rhs_i;
    end
    if (cmd_i.mul) begin
      prod_q <= ACC_W'(coef_q) * ACC_W'(rd_q);
    end
    if (cmd_i.num) begin
      num_mag_q <= num_val[ACC_W-1] ? (-num_val) : num_val;
      neg_q     <= num_val[ACC_W-1] ^ coef_q[DATA_W-1];
      ov_q      <= sum_ov_q | num_ovf;
    end
    if (cmd_i.res_order) begin
      res_index_q  <= row_q;
      res_sol_q    <= '0;
      res_status_q <= STATUS_ORDER;
      res_last_q   <= 1'b0;
    end else if (cmd_i.finish) begin
      res_index_q  <= row_q;
      res_sol_q    <= x_d;
      res_status_q <= x_status;
      res_last_q   <= is_last;
    end
    if (cmd_i.out_load) begin
      out_index_q  <= res_index_q;
      out_sol_q    <= res_sol_q;
      out_status_q <= res_status_q;
      out_last_q   <= res_last_q;
    end
  end

  // solution store, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      store_q[row_q[ADDR_W-1:0]] <= x_d;
    end
    if (cmd_i.rd_issue) begin
      rd_q <= store_q[col_q[ADDR_W-1:0]];
    end
  end

  assign index_o    = out_index_q;
  assign solution_o = out_sol_q;
  assign status_o   = out_status_q;
  assign last_o     = out_last_q;

endmodule

// ===== rtl/core/ltfs_ctrl.sv =====
// Controller: sequences each beat through check, multiply-accumulate or
// divide, and owns the output valid. Depends on ltfs_pkg.
module ltfs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  ltfs_pkg::ltfs_sts_t  sts_i,
  output ltfs_pkg::ltfs_cmd_t  cmd_o
);
  import ltfs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_ACC,
    S_NUM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_FIN,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts_i.in_order) begin
          cmd_o.res_order = 1'b1;
          state_d         = S_EMIT;
        end else if (sts_i.is_diag) begin
          state_d = S_NUM;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = S_IDLE;
      end
      S_NUM: begin
        cmd_o.num = 1'b1;
        state_d   = sts_i.coef_zero ? S_FIN : S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/lower_triangular_forward_solve.sv =====
// Lower-triangular forward-substitution solver, top level.
// Depends on ltfs_pkg, ltfs_ctrl, ltfs_dp (with ltfs_div) and the macros header.
//
//   channel   handshake                  payload
//   -------   -------------------------  ---------------------------------
//   in        in_valid_i / in_stall_o    row_i, col_i, coef_i, rhs_i
//   out       out_valid_o / out_stall_i  index_o, solution_o, status_o, last_o
//   cfg       cfg_we_i                   cfg_wdata_i (matrix_size)
//
// Off-diagonal beat: capture, check + store read, multiply, accumulate.
// Diagonal beat: capture, check, numerator, 64-step bit-serial divider, finish,
// emit; a zero diagonal skips the divider. Out-of-order: capture, check, emit.
// A finished result sits in the output register while the next beat is taken.
// Reset clears the sequencer, sum and size (64); the solution store is not cleared.
`include "lower_triangular_forward_solve_macros.svh"

module lower_triangular_forward_solve (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ltfs_pkg::SIZE_W-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ltfs_pkg::ROW_W-1:0]          row_i,
  input  logic [ltfs_pkg::ROW_W-1:0]          col_i,
  input  logic signed [ltfs_pkg::DATA_W-1:0]  coef_i,
  input  logic signed [ltfs_pkg::DATA_W-1:0]  rhs_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ltfs_pkg::ROW_W-1:0]          index_o,
  output logic signed [ltfs_pkg::DATA_W-1:0]  solution_o,
  output logic [1:0]                         status_o,
  output logic                               last_o
);
  import ltfs_pkg::*;

  ltfs_cmd_t cmd;
  ltfs_sts_t sts;

  ltfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ltfs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .coef_i      (coef_i),
    .rhs_i       (rhs_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .index_o     (index_o),
    .solution_o  (solution_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  `LTFS_ASSERT_IMP(a_order_result_clean, out_valid_o && (status_o == STATUS_ORDER),
    (solution_o == '0) && !last_o, "out-of-order result carries data")
  `LTFS_ASSERT_IMP(a_zero_diag_result, out_valid_o && (status_o == STATUS_ZERO_DIAG),
    solution_o == '0, "zero-diagonal result is not zero")
  `LTFS_ASSERT_NXT(a_busy_after_beat, in_valid_i && !in_stall_o, in_stall_o,
    "input taken again right after a beat")

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for lower_triangular_forward_solve: drives triangular systems beat by
// beat and checks every solution against a bit-exact Q16.16 forward-substitution predictor.
// Depends on ltfs_pkg and the solver RTL only.
`timescale 1ns / 1ps

module tb;
  import ltfs_pkg::*;

  localparam int DRAIN_CYCLES = 100;  // longer than one diagonal divide
  localparam int PHASE_BEATS  = 160;
  localparam int NUM_PHASES   = 11;
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, 63'b0};

  typedef struct packed {
    logic [ROW_W-1:0]         row;
    logic [ROW_W-1:0]         col;
    logic signed [DATA_W-1:0] coef;
    logic signed [DATA_W-1:0] rhs;
  } beat_t;

  typedef struct packed {
    logic [ROW_W-1:0]         index;
    logic signed [DATA_W-1:0] solution;
    status_e                  status;
    logic                     last;
  } solution_t;

  typedef struct {
    beat_t     b;
    bit        typed;
    solution_t r;
  } plan_row_t;

  typedef enum {HOLD_NONE, HOLD_LIGHT, HOLD_HEAVY, HOLD_PERIODIC} hold_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [SIZE_W-1:0]        cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [ROW_W-1:0]         row_i;
  logic [ROW_W-1:0]         col_i;
  logic signed [DATA_W-1:0] coef_i;
  logic signed [DATA_W-1:0] rhs_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [ROW_W-1:0]         index_o;
  logic signed [DATA_W-1:0] solution_o;
  logic [1:0]               status_o;
  logic                     last_o;

  lower_triangular_forward_solve dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .row_i      (row_i),
    .col_i      (col_i),
    .coef_i     (coef_i),
    .rhs_i      (rhs_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .index_o    (index_o),
    .solution_o (solution_o),
    .status_o   (status_o),
    .last_o     (last_o)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic signed [DATA_W-1:0] x_store [STORE_DEPTH];
  logic signed [63:0]       acc_sum;
  bit                       acc_sat;
  logic [ROW_W-1:0]         want_row;
  logic [ROW_W-1:0]         want_col;
  logic [SIZE_W-1:0]        size_reg;

  solution_t pending_solutions[$];
  int        errors = 0;
  int        beats_sent = 0;
  int        solutions_checked = 0;
  int        burst_left = 0;

  logic [SIZE_W-1:0] phase_sizes [NUM_PHASES] = '{
    7'd3, 7'd0, 7'd1, 7'd127, 7'd64, 7'd2, 7'd5, 7'd8, 7'd16, 7'd4, 7'd6
  };

  // Directed opening, from reset (size 64). Typed rows carry their solution.
  plan_row_t plan [24] = '{
    '{'{6'd1, 6'd0, 32'h0, 32'h0}, 1'b1, '{6'd1, 32'h0, STATUS_ORDER, 1'b0}},
    '{'{6'd0, 6'd0, 32'h0, 32'h0005_0000}, 1'b1, '{6'd0, 32'h0, STATUS_ZERO_DIAG, 1'b0}},
    '{'{6'd1, 6'd0, 32'h7FFF_FFFF, 32'h0}, 1'b0, '0},
    '{'{6'd1, 6'd1, 32'h0001_0000, 32'h7FFF_FFFF}, 1'b1,
      '{6'd1, 32'h7FFF_FFFF, STATUS_OK, 1'b0}},
    '{'{6'd2, 6'd0, 32'h8000_0000, 32'h0}, 1'b0, '0},
    '{'{6'd2, 6'd1, 32'h8000_0000, 32'h0}, 1'b0, '0},
    '{'{6'd2, 6'd2, 32'h0000_0001, 32'h0}, 1'b1, '{6'd2, 32'h7FFF_FFFF, STATUS_SAT, 1'b0}},
    '{'{6'd3, 6'd5, 32'h0, 32'h0}, 1'b1, '{6'd3, 32'h0, STATUS_ORDER, 1'b0}},
    '{'{6'd3, 6'd0, 32'hFFFF_FFFF, 32'h8000_0000}, 1'b0, '0},
    '{'{6'd3, 6'd1, 32'h7FFF_FFFF, 32'h0}, 1'b0, '0},
    '{'{6'd3, 6'd2, 32'h7FFF_FFFF, 32'h0}, 1'b0, '0},
    '{'{6'd3, 6'd3, 32'hFFFF_0000, 32'h8000_0000}, 1'b0, '0},
    '{'{6'd4, 6'd0, 32'h0, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{6'd4, 6'd1, 32'h0, 32'h0}, 1'b0, '0},
    '{'{6'd4, 6'd2, 32'h0, 32'h0}, 1'b0, '0},
    '{'{6'd4, 6'd3, 32'h0, 32'h0}, 1'b0, '0},
    '{'{6'd4, 6'd4, 32'hFFFF_FFFF, 32'h8000_0000}, 1'b1,
      '{6'd4, 32'h7FFF_FFFF, STATUS_SAT, 1'b0}},
    '{'{6'd63, 6'd63, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b1,
      '{6'd63, 32'h0, STATUS_ORDER, 1'b0}},
    '{'{6'd5, 6'd0, 32'h8000_0000, 32'h0}, 1'b0, '0},
    // three products near 2^62 push the sum past the 64-bit limit
    '{'{6'd5, 6'd1, 32'h7FFF_FFFF, 32'h0}, 1'b0, '0},
    '{'{6'd5, 6'd2, 32'h7FFF_FFFF, 32'h0}, 1'b0, '0},
    '{'{6'd5, 6'd3, 32'h7FFF_FFFF, 32'h0}, 1'b0, '0},
    '{'{6'd5, 6'd4, 32'h7FFF_FFFF, 32'h0}, 1'b0, '0},
    '{'{6'd5, 6'd5, 32'h0001_0000, 32'h0}, 1'b0, '0}
  };

  // Forward-substitution step: updates the sum or solves x(row); returns 1 on a result.
  function automatic bit solve_beat(input beat_t b, output solution_t r);
    logic signed [63:0]       prod, scaled, num;
    logic signed [64:0]       wide, q, n65, d65;
    logic signed [DATA_W-1:0] x;
    int                       eff;
    bit                       ov, is_last;
    eff = (size_reg == 0) ? 1 : ((size_reg > SIZE_LIMIT) ? int'(SIZE_LIMIT) : int'(size_reg));
    r = '{index: b.row, solution: '0, status: STATUS_ORDER, last: 1'b0};
    if (b.row != want_row || b.col != want_col) return 1'b1;
    if (b.col < b.row) begin
      prod = longint'(b.coef) * longint'(x_store[b.col]);
      wide = {acc_sum[63], acc_sum} + {prod[63], prod};
      if (wide[64] != wide[63]) begin
        acc_sat = 1'b1;
        acc_sum = wide[64] ? S64_MIN : S64_MAX;
      end else begin
        acc_sum = wide[63:0];
      end
      want_col = b.col + 6'd1;
      return 1'b0;
    end
    ov = acc_sat;
    is_last = (int'(b.row) + 1 >= eff);
    scaled = longint'(b.rhs) <<< FRAC_BITS;
    wide = {scaled[63], scaled} - {acc_sum[63], acc_sum};
    if (wide[64] != wide[63]) begin
      ov = 1'b1;
      num = wide[64] ? S64_MIN : S64_MAX;
    end else begin
      num = wide[63:0];
    end
    if (b.coef == 0) begin
      x = '0;
      r.status = STATUS_ZERO_DIAG;
    end else begin
      n65 = {num[63], num};
      d65 = {{33{b.coef[31]}}, b.coef};
      q = n65 / d65;  // truncates toward zero
      if (q[64:31] != {34{q[31]}}) begin
        ov = 1'b1;
        x = q[64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        x = q[31:0];
      end
      r.status = ov ? STATUS_SAT : STATUS_OK;
    end
    x_store[b.row] = x;
    acc_sum = '0;
    acc_sat = 1'b0;
    want_col = '0;
    want_row = is_last ? 6'd0 : b.row + 6'd1;
    r.solution = x;
    r.last = is_last;
    return 1'b1;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value(input bit divisor);
    logic signed [DATA_W-1:0] v;
    int unsigned              mode;
    mode = $urandom_range(0, 19);
    if (mode < 5) begin
      v = $urandom;
    end else if (mode < 7) begin
      case ($urandom_range(0, 4))
        0:       v = 32'sh7FFF_FFFF;
        1:       v = 32'sh8000_0000;
        2:       v = -32'sd1;
        3:       v = 32'sd1;
        default: v = '0;
      endcase
    end else if (divisor) begin
      // mostly magnitudes around 0.5 .. 4.0 so solutions stay in range
      v = $urandom_range(32'h8000, 32'h4_0000);
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      v = $signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
    end
    return v;
  endfunction

  task automatic drive_beat(input beat_t b, input bit typed, input solution_t typed_res);
    solution_t r;
    bit        has;
    int        gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    row_i      <= b.row;
    col_i      <= b.col;
    coef_i     <= b.coef;
    rhs_i      <= b.rhs;
    do @(posedge clk_i); while (in_stall_o);
    has = solve_beat(b, r);
    if (typed) r = typed_res;
    if (has) pending_solutions.push_back(r);
    beats_sent++;
  endtask

  // Size writes happen only with the solver drained.
  task automatic write_size(input logic [SIZE_W-1:0] v);
    in_valid_i <= 1'b0;
    while (pending_solutions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = v;
  endtask

  // receiver: stall pattern changes character each time its random hold count runs out
  hold_e       hold_mode = HOLD_NONE;
  int          hold_left = 0;
  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) begin
    solution_t e;
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_solutions.size() == 0) begin
          $error("result with nothing expected: index %0d solution %h status %0d",
                 index_o, solution_o, status_o);
          errors++;
        end else begin
          e = pending_solutions.pop_front();
          solutions_checked++;
          if (index_o !== e.index) begin
            $error("index: expected %0d, got %0d", e.index, index_o);
            errors++;
          end
          if (solution_o !== e.solution) begin
            $error("solution (row %0d): expected %h, got %h", e.index, e.solution, solution_o);
            errors++;
          end
          if (status_o !== e.status) begin
            $error("status (row %0d): expected %0d, got %0d", e.index, e.status, status_o);
            errors++;
          end
          if (last_o !== e.last) begin
            $error("last (row %0d): expected %0b, got %0b", e.index, e.last, last_o);
            errors++;
          end
        end
      end
      if (hold_left == 0) begin
        hold_mode = hold_e'($urandom_range(0, 3));
        hold_left = $urandom_range(50, 400);
      end else begin
        hold_left--;
      end
      case (hold_mode)
        HOLD_LIGHT:    out_stall_i <= ($urandom_range(0, 9) < 3);
        HOLD_HEAVY:    out_stall_i <= ($urandom_range(0, 9) < 8);
        HOLD_PERIODIC: out_stall_i <= cycle_cnt[2];
        default:       out_stall_i <= 1'b0;
      endcase
    end
  end

  initial begin
    beat_t b;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    row_i       <= '0;
    col_i       <= '0;
    coef_i      <= '0;
    rhs_i       <= '0;
    out_stall_i <= 1'b0;
    foreach (x_store[i]) x_store[i] = '0;
    acc_sum  = '0;
    acc_sat  = 1'b0;
    want_row = '0;
    want_col = '0;
    size_reg = SIZE_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) drive_beat(plan[i].b, plan[i].typed, plan[i].r);

    // The first write lands mid-system, so its diagonal closes the system early.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_size(phase_sizes[p]);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 99) < 8) begin
          b.row = ROW_W'($urandom);
          b.col = ROW_W'($urandom);
        end else begin
          b.row = want_row;
          b.col = want_col;
        end
        b.coef = pick_value((b.row == b.col) && ($urandom_range(0, 19) != 0));
        b.rhs  = pick_value(1'b0);
        drive_beat(b, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_solutions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d beats across %0d size settings; %0d solutions checked, %0d errors.",
             beats_sent, NUM_PHASES + 1, solutions_checked, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d solutions outstanding", pending_solutions.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ltfs_pkg.sv
rtl/core/ltfs_div.sv
rtl/core/ltfs_dp.sv
rtl/core/ltfs_ctrl.sv
rtl/core/lower_triangular_forward_solve.sv
bench/tb.sv
